>>> src/rau_pkg.sv
// Package for the rational arithmetic unit: payload types, codes and defaults.
`default_nettype none
package rau_pkg;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } rsp_t;
endpackage
`default_nettype wire

>>> src/rational_arithmetic_unit.sv
// Rational arithmetic unit: top level with sequencer and shared datapath.
// One request at a time. The unit splits the operands into sign and magnitude,
// then runs a gcd of the denominators (add/subtract), scaling, and a final gcd
// reduction. Every gcd step and every division uses one shared restoring
// divider on 64-bit values, one quotient bit per cycle. Each Euclidean step is
// one divide. Products use one 32x32 multiplier, one per cycle. A zero
// denominator, or a zero divisor numerator on divide, is caught in the split
// state, which goes straight to the output state. Any other request runs for
// a time that depends on the operands, and the Euclidean remainder loop
// dominates it. The result is held on m_ until taken, and s_ready
// is low from acceptance until the result has been delivered.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  rau_pkg::req_t     s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output rau_pkg::rsp_t     m_data
);
    localparam int WW = 2 * DATA_WIDTH;
    localparam logic [WW-1:0] HALF = {{(WW-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
    localparam int CW = $clog2(WW + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SPLIT = 13'b0000000000010,
        S_G1    = 13'b0000000000100,
        S_DV1   = 13'b0000000001000,
        S_DV2   = 13'b0000000010000,
        S_M1    = 13'b0000000100000,
        S_M2    = 13'b0000001000000,
        S_M3    = 13'b0000010000000,
        S_COMB  = 13'b0000100000000,
        S_G2    = 13'b0001000000000,
        S_DV3   = 13'b0010000000000,
        S_DV4   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    rau_pkg::req_t req_reg;
    logic [1:0] op_reg;
    logic [DATA_WIDTH-1:0] ma_reg, da_reg, mb_reg, db_reg;
    logic sa_reg, sb_reg, neg_reg;
    logic [WW-1:0] n_reg, d_reg, gx_reg, gy_reg, g_reg, t1_reg, t2_reg;
    logic out_valid_reg;
    rau_pkg::rsp_t out_reg;

    // shared divider
    logic dv_busy_reg, dv_start;
    logic [WW-1:0] dv_num_reg, dv_den_reg, dv_q_reg, dv_r_reg;
    logic [CW-1:0] dv_cnt_reg;
    logic [WW-1:0] dv_a, dv_b;
    logic [WW:0] dv_sh;
    logic dv_done;

    // shared multiplier operands
    logic [DATA_WIDTH-1:0] mul_x, mul_y;
    logic [WW-1:0] mul_p;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [31:0] raw);
        logic [DATA_WIDTH-1:0] v;
        v = raw[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    assign dv_sh = {dv_r_reg, dv_num_reg[WW-1]};
    assign dv_done = dv_busy_reg && (dv_cnt_reg == CW'(0));
    assign mul_p = WW'(mul_x) * WW'(mul_y);
    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_busy_reg <= 1'b0;
            dv_cnt_reg <= '0;
        end else if (dv_start) begin
            dv_busy_reg <= 1'b1;
            dv_cnt_reg <= CW'(WW);
            dv_num_reg <= dv_a;
            dv_den_reg <= dv_b;
            dv_r_reg <= '0;
            dv_q_reg <= '0;
        end else if (dv_busy_reg) begin
            if (dv_cnt_reg == CW'(0)) begin
                dv_busy_reg <= 1'b0;
            end else begin
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
                dv_num_reg <= dv_num_reg << 1;
                if (dv_sh >= {1'b0, dv_den_reg}) begin
                    dv_r_reg <= WW'(dv_sh - {1'b0, dv_den_reg});
                    dv_q_reg <= {dv_q_reg[WW-2:0], 1'b1};
                end else begin
                    dv_r_reg <= dv_sh[WW-1:0];
                    dv_q_reg <= {dv_q_reg[WW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        dv_start = 1'b0;
        dv_a = gx_reg;
        dv_b = gy_reg;
        mul_x = ma_reg;
        mul_y = db_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) state_next = S_SPLIT;
            S_SPLIT: begin
                if (mag(req_reg.a_den) == '0 || mag(req_reg.b_den) == '0 ||
                    (req_reg.cmd == rau_pkg::CMD_DIV && mag(req_reg.b_num) == '0)) begin
                    state_next = S_OUT;
                end else if (req_reg.cmd == rau_pkg::CMD_ADD ||
                             req_reg.cmd == rau_pkg::CMD_SUB) begin
                    state_next = S_G1;
                end else begin
                    state_next = S_M1;
                end
            end
            S_G1, S_G2: begin
                if (gy_reg == '0) begin
                    state_next = (state_reg == S_G1) ? S_DV1 : S_DV3;
                    dv_start = 1'b1;
                    dv_a = (state_reg == S_G1) ? WW'(da_reg) : n_reg;
                    dv_b = gx_reg;
                end else if (!dv_busy_reg) begin
                    dv_start = 1'b1;
                end
            end
            S_DV1: if (dv_done) begin
                state_next = S_DV2;
                dv_start = 1'b1;
                dv_a = WW'(db_reg);
                dv_b = g_reg;
            end
            S_DV2: if (dv_done) state_next = S_M1;
            S_M1: begin
                if (op_reg == rau_pkg::CMD_MUL) begin
                    mul_x = ma_reg; mul_y = mb_reg;
                end else if (op_reg == rau_pkg::CMD_DIV) begin
                    mul_x = ma_reg; mul_y = db_reg;
                end else begin
                    mul_x = ma_reg; mul_y = t2_reg[DATA_WIDTH-1:0];
                end
                state_next = S_M2;
            end
            S_M2: begin
                if (op_reg == rau_pkg::CMD_MUL) begin
                    mul_x = da_reg; mul_y = db_reg;
                    state_next = S_COMB;
                end else if (op_reg == rau_pkg::CMD_DIV) begin
                    mul_x = da_reg; mul_y = mb_reg;
                    state_next = S_COMB;
                end else begin
                    mul_x = mb_reg; mul_y = t1_reg[DATA_WIDTH-1:0];
                    state_next = S_M3;
                end
            end
            // common denominator: da * (db / g)
            S_M3: begin
                mul_x = da_reg; mul_y = t2_reg[DATA_WIDTH-1:0];
                state_next = S_COMB;
            end
            S_COMB: state_next = S_G2;
            S_DV3: if (dv_done) begin
                state_next = S_DV4;
                dv_start = 1'b1;
                dv_a = d_reg;
                dv_b = g_reg;
            end
            S_DV4: if (dv_done) state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic nz;
    logic [WW-1:0] lim;
    assign nz = neg_reg && (n_reg != '0);
    assign lim = nz ? HALF : HALF - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) req_reg <= s_data;
                S_SPLIT: begin
                    op_reg <= req_reg.cmd;
                    ma_reg <= mag(req_reg.a_num);
                    da_reg <= mag(req_reg.a_den);
                    mb_reg <= mag(req_reg.b_num);
                    db_reg <= mag(req_reg.b_den);
                    sa_reg <= req_reg.a_num[DATA_WIDTH-1] ^ req_reg.a_den[DATA_WIDTH-1];
                    sb_reg <= (req_reg.b_num[DATA_WIDTH-1] ^ req_reg.b_den[DATA_WIDTH-1])
                              ^ (req_reg.cmd == rau_pkg::CMD_SUB);
                    gx_reg <= WW'(mag(req_reg.a_den));
                    gy_reg <= WW'(mag(req_reg.b_den));
                end
                S_G1, S_G2: begin
                    if (gy_reg == '0) begin
                        g_reg <= gx_reg;
                    end else if (dv_done) begin
                        gx_reg <= gy_reg;
                        gy_reg <= dv_r_reg;
                    end
                end
                S_DV1: if (dv_done) t1_reg <= dv_q_reg;
                S_DV2: if (dv_done) t2_reg <= dv_q_reg;
                S_M1: n_reg <= mul_p;
                S_M2: begin
                    if (op_reg == rau_pkg::CMD_MUL || op_reg == rau_pkg::CMD_DIV) begin
                        d_reg <= mul_p;
                    end
                    t1_reg <= mul_p;
                end
                S_M3: d_reg <= mul_p;
                S_COMB: begin
                    if (op_reg == rau_pkg::CMD_MUL || op_reg == rau_pkg::CMD_DIV) begin
                        neg_reg <= sa_reg ^ sb_reg;
                    end else if (sa_reg == sb_reg) begin
                        n_reg <= n_reg + t1_reg; neg_reg <= sa_reg;
                    end else if (n_reg >= t1_reg) begin
                        n_reg <= n_reg - t1_reg; neg_reg <= sa_reg;
                    end else begin
                        n_reg <= t1_reg - n_reg; neg_reg <= sb_reg;
                    end
                    gx_reg <= (op_reg == rau_pkg::CMD_MUL || op_reg == rau_pkg::CMD_DIV)
                              ? n_reg
                              : ((sa_reg == sb_reg) ? n_reg + t1_reg
                                 : (n_reg >= t1_reg ? n_reg - t1_reg : t1_reg - n_reg));
                    gy_reg <= d_reg;
                end
                S_DV3: if (dv_done) n_reg <= dv_q_reg;
                S_DV4: if (dv_done) d_reg <= dv_q_reg;
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    if (da_reg == '0 || db_reg == '0 ||
                        (op_reg == rau_pkg::CMD_DIV && mb_reg == '0)) begin
                        out_reg <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO_DEN};
                    end else if (d_reg > HALF - 1'b1 || n_reg > lim) begin
                        out_reg <= '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVERFLOW};
                    end else begin
                        out_reg <= '{res_num: 32'(nz ? (~n_reg + 1'b1) : n_reg),
                                     res_den: 31'(d_reg), status: rau_pkg::ST_OK};
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))) else $error("result dropped");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !dv_busy_reg) else $error("divider busy in idle");
endmodule
`default_nettype wire
